/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sdsf_pkg.sv */
// ----------------------------------------------------------------------------
// SD SPI command framer package
// Payload types, codes, frame byte positions and the CRC7 byte update.
// ----------------------------------------------------------------------------
package sdsf_pkg;

  // Item codes carried in the command field.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_RX    = 1'b1;

  // Fixed bytes and register reset value.
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [6:0] CRC7_POLY   = 7'h09;
  localparam logic [7:0] POLL_RESET  = 8'd100;

  // Byte positions within one command frame.
  localparam logic [2:0] BYTE_FLUSH = 3'd0;
  localparam logic [2:0] BYTE_CMD   = 3'd1;
  localparam logic [2:0] BYTE_ARG3  = 3'd2;
  localparam logic [2:0] BYTE_ARG2  = 3'd3;
  localparam logic [2:0] BYTE_ARG1  = 3'd4;
  localparam logic [2:0] BYTE_ARG0  = 3'd5;
  localparam logic [2:0] BYTE_CRC   = 3'd6;
  localparam logic [2:0] BYTE_POLL  = 3'd7;

  // One input item.
  typedef struct packed {
    logic        command;
    logic [6:0]  command_byte;
    logic [31:0] argument;
    logic [7:0]  rx_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_out;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       timed_out;
    logic       last;
  } result_t;

  // Status of the frame sequencer towards the control logic.
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
  } frame_status_t;

  // Shift one byte, most significant bit first, through the CRC7 register.
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc, input logic [7:0] data);
    logic [6:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[6] ^ data[i];
      c  = {c[5:0], 1'b0};
      if (fb) begin
        c = c ^ CRC7_POLY;
      end
    end
    return c;
  endfunction

endpackage

/* hdl/sdsf_frame_seq.sv */
// ----------------------------------------------------------------------------
// SD SPI command frame sequencer
// Steps through the eight frame bytes, one per advance, and folds the
// command and argument bytes into the CRC7 on the way.
// ----------------------------------------------------------------------------
module sdsf_frame_seq (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  logic [6:0]             command_byte,
  input  logic [31:0]            argument,
  output sdsf_pkg::frame_status_t status
);

  logic [2:0] cnt;
  logic [6:0] crc;
  logic [7:0] tx_byte;

  // Select the byte for the current frame position.
  always_comb begin
    unique case (cnt)
      sdsf_pkg::BYTE_FLUSH: tx_byte = sdsf_pkg::IDLE_BYTE;
      sdsf_pkg::BYTE_CMD:   tx_byte = {1'b0, command_byte};
      sdsf_pkg::BYTE_ARG3:  tx_byte = argument[31:24];
      sdsf_pkg::BYTE_ARG2:  tx_byte = argument[23:16];
      sdsf_pkg::BYTE_ARG1:  tx_byte = argument[15:8];
      sdsf_pkg::BYTE_ARG0:  tx_byte = argument[7:0];
      sdsf_pkg::BYTE_CRC:   tx_byte = {crc, 1'b1};
      sdsf_pkg::BYTE_POLL:  tx_byte = sdsf_pkg::IDLE_BYTE;
      default:              tx_byte = sdsf_pkg::IDLE_BYTE;
    endcase
  end

  assign status.tx_byte   = tx_byte;
  assign status.frame_end = (cnt == sdsf_pkg::BYTE_POLL);

  // Byte position counter; wraps back to the flush byte after the poll.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= sdsf_pkg::BYTE_FLUSH;
    end else if (advance) begin
      cnt <= cnt + 3'd1;
    end
  end

  // CRC7 is cleared on the flush byte and updated over the five body bytes.
  always_ff @(posedge clk) begin
    if (advance) begin
      if (cnt == sdsf_pkg::BYTE_FLUSH) begin
        crc <= 7'd0;
      end else if (cnt <= sdsf_pkg::BYTE_ARG0) begin
        crc <= sdsf_pkg::crc7_byte(crc, tx_byte);
      end
    end
  end

endmodule

/* hdl/sdsf_result_reg.sv */
// ----------------------------------------------------------------------------
// SD SPI command framer result register
// Holds one result item until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module sdsf_result_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  sdsf_pkg::result_t load_item,
  output logic              free,
  output logic              res_valid,
  input  logic              res_stall,
  output sdsf_pkg::result_t res
);

  // The register can take a new result when empty or when its transfer completes.
  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res <= load_item;
    end
  end

endmodule

/* hdl/sd_spi_command_framer.sv */
// ----------------------------------------------------------------------------
// SD SPI command framer
// Builds SPI-mode command frames with CRC7 and waits for the R1 reply.
// ----------------------------------------------------------------------------
// Flow: an accepted item is held in the input register and decided from there;
//   its first result enters the result register once that register is free.
// Output: a received byte gives at most one result; a start gives eight frame
//   bytes, one per cycle from the frame sequencer while results are taken.
// Reset (rst, synchronous): clears the item and result registers, the wait
//   state and the poll count, and sets poll_limit to 100.
module sd_spi_command_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [7:0]        cfg_data,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  sdsf_pkg::item_t   cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output sdsf_pkg::result_t res
);

  `include "assert_macros.svh"

  logic                    ir_valid;
  sdsf_pkg::item_t         ir;
  logic [7:0]              poll_limit;
  logic                    waiting;
  logic                    waiting_next;
  logic [7:0]              polls_left;
  logic [7:0]              polls_left_next;
  logic                    done;
  logic                    advance;
  logic                    load;
  logic                    free;
  sdsf_pkg::result_t       load_item;
  sdsf_pkg::frame_status_t fs;

  // Poll limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= sdsf_pkg::POLL_RESET;
    end else if (cfg_write) begin
      poll_limit <= cfg_data;
    end
  end

  // Input register; loaded when empty or when the held item finishes this cycle.
  assign cmd_stall = ir_valid && !done;

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (!cmd_stall) begin
      ir_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      ir <= cmd;
    end
  end

  sdsf_frame_seq u_frame_seq (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .command_byte (ir.command_byte),
    .argument     (ir.argument),
    .status       (fs)
  );

  // Decide what the held item produces and how the wait state moves.
  always_comb begin
    done            = 1'b0;
    advance         = 1'b0;
    load            = 1'b0;
    load_item       = '0;
    waiting_next    = waiting;
    polls_left_next = polls_left;
    if (ir_valid) begin
      if (ir.command == sdsf_pkg::CMD_START) begin
        if (waiting) begin
          done = 1'b1;
        end else if (free) begin
          advance            = 1'b1;
          load               = 1'b1;
          load_item.tx_valid = 1'b1;
          load_item.tx_out   = fs.tx_byte;
          load_item.last     = fs.frame_end;
          done               = fs.frame_end;
          if (fs.frame_end) begin
            waiting_next    = 1'b1;
            polls_left_next = poll_limit;
          end
        end
      end else begin
        if (!waiting) begin
          done = 1'b1;
        end else if (free) begin
          load           = 1'b1;
          done           = 1'b1;
          load_item.last = 1'b1;
          if (ir.rx_byte != sdsf_pkg::IDLE_BYTE) begin
            load_item.reply_valid = 1'b1;
            load_item.reply_byte  = ir.rx_byte;
            waiting_next          = 1'b0;
            polls_left_next       = 8'd0;
          end else if (polls_left != 8'd0) begin
            load_item.tx_valid = 1'b1;
            load_item.tx_out   = sdsf_pkg::IDLE_BYTE;
            polls_left_next    = polls_left - 8'd1;
          end else begin
            load_item.reply_valid = 1'b1;
            load_item.reply_byte  = sdsf_pkg::IDLE_BYTE;
            load_item.timed_out   = 1'b1;
            waiting_next          = 1'b0;
            polls_left_next       = 8'd0;
          end
        end
      end
    end
  end

  // Wait state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      waiting    <= 1'b0;
      polls_left <= 8'd0;
    end else begin
      waiting    <= waiting_next;
      polls_left <= polls_left_next;
    end
  end

  sdsf_result_reg u_result_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .load_item (load_item),
    .free      (free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // Checks on the wait state and the results it produces.
  `ASSERT_IMPLIES(a_polls_only_waiting, polls_left != 8'd0, waiting, "polls left while idle")
  `ASSERT_NEXT(a_frame_end_waits, advance && fs.frame_end,
               waiting && (polls_left == $past(poll_limit)), "frame end did not arm the wait")
  `ASSERT_NEXT(a_reply_ends_wait, load && load_item.reply_valid, !waiting,
               "reply did not end the wait")
  `ASSERT_IMPLIES(a_reply_is_last, load && load_item.reply_valid,
                  load_item.last && !load_item.tx_valid, "reply result not marked last")

endmodule

/* tb/sv/sd_spi_command_framer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SD SPI command framer testbench
// Sends start and received-byte items to the framer and predicts every
// transmit byte and reply that they cause. It checks each result transfer in
// order against the prediction, under several mixes of sender idling and
// receiver stalling, poll limits at both extremes and one long receiver
// hold-off that backs the framer up into its input.
// ----------------------------------------------------------------------------
module sd_spi_command_framer_tb;

  localparam int RESET_CYCLES    = 3;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_CYCLES     = 200;
  localparam int PHASE_ITEMS     = 25;
  localparam int CYCLE_LIMIT     = 400000;

  // Block inputs, all known from time zero.
  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    cfg_write = 1'b0;
  logic    [7:0] cfg_data = 8'h00;
  logic    cmd_valid = 1'b0;
  sdsf_pkg::item_t   cmd       = '0;
  logic    res_stall = 1'b0;
  logic    cmd_stall;
  logic    res_valid;
  sdsf_pkg::result_t res;

  // Shadow of the framer's register and reply-wait state.
  logic [7:0] poll_limit_m  = sdsf_pkg::POLL_RESET;
  logic       card_waiting  = 1'b0;
  logic [7:0] polls_left_m  = 8'h00;
  int         answered_items = 0;

  // Predicted result transfers, oldest first.
  sdsf_pkg::result_t spi_out_q[$];

  int fail_count    = 0;
  int cycle_count   = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;

  sd_spi_command_framer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Seven-bit CRC over one byte, most significant bit first.
  function automatic logic [6:0] crc7_next(input logic [6:0] crc, input logic [7:0] data_byte);
    logic [6:0] sr;
    logic       fb;
    sr = crc;
    for (int n = 0; n < 8; n++) begin
      fb = sr[6] ^ data_byte[7 - n];
      sr = {sr[5:0], 1'b0} ^ (fb ? sdsf_pkg::CRC7_POLY : 7'h00);
    end
    return sr;
  endfunction

  // Works out the results of one accepted item and advances the shadow state.
  function automatic void predict_framer(input sdsf_pkg::item_t it);
    logic [7:0] frame [8];
    logic [6:0] crc;
    if (it.command == sdsf_pkg::CMD_START) begin
      if (card_waiting) begin
        return;
      end
      frame[sdsf_pkg::BYTE_FLUSH] = sdsf_pkg::IDLE_BYTE;
      frame[sdsf_pkg::BYTE_CMD]   = {1'b0, it.command_byte};
      frame[sdsf_pkg::BYTE_ARG3]  = it.argument[31:24];
      frame[sdsf_pkg::BYTE_ARG2]  = it.argument[23:16];
      frame[sdsf_pkg::BYTE_ARG1]  = it.argument[15:8];
      frame[sdsf_pkg::BYTE_ARG0]  = it.argument[7:0];
      crc = 7'h00;
      for (int k = sdsf_pkg::BYTE_CMD; k <= sdsf_pkg::BYTE_ARG0; k++) begin
        crc = crc7_next(crc, frame[k]);
      end
      frame[sdsf_pkg::BYTE_CRC]  = {crc, 1'b1};
      frame[sdsf_pkg::BYTE_POLL] = sdsf_pkg::IDLE_BYTE;
      for (int k = 0; k < 8; k++) begin
        spi_out_q.push_back(sdsf_pkg::result_t'{1'b1, frame[k], 1'b0, 8'h00, 1'b0, k == 7});
      end
      card_waiting = 1'b1;
      polls_left_m = poll_limit_m;
      answered_items++;
    end else begin
      if (!card_waiting) begin
        return;
      end
      if (it.rx_byte != sdsf_pkg::IDLE_BYTE) begin
        spi_out_q.push_back(sdsf_pkg::result_t'{1'b0, 8'h00, 1'b1, it.rx_byte, 1'b0, 1'b1});
        card_waiting = 1'b0;
        polls_left_m = 8'h00;
      end else if (polls_left_m != 8'h00) begin
        polls_left_m = polls_left_m - 8'd1;
        spi_out_q.push_back(sdsf_pkg::result_t'{1'b1, sdsf_pkg::IDLE_BYTE,
                                                1'b0, 8'h00, 1'b0, 1'b1});
      end else begin
        spi_out_q.push_back(sdsf_pkg::result_t'{1'b0, 8'h00,
                                                1'b1, sdsf_pkg::IDLE_BYTE, 1'b1, 1'b1});
        card_waiting = 1'b0;
        polls_left_m = 8'h00;
      end
      answered_items++;
    end
  endfunction

  // An item with every field random and the given code.
  function automatic sdsf_pkg::item_t random_fields(input logic code);
    sdsf_pkg::item_t it;
    it.command = code;
    if ($urandom_range(9) == 0) begin
      it.command_byte = 7'($urandom_range(127));
    end else begin
      it.command_byte = 7'($urandom_range(127, 64));
    end
    case ($urandom_range(9))
      0: it.argument = 32'h0000_0000;
      1: it.argument = 32'hFFFF_FFFF;
      default: it.argument = $urandom;
    endcase
    it.rx_byte = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic sdsf_pkg::item_t start_item(input logic [6:0] cmd_byte,
                                                 input logic [31:0] arg);
    sdsf_pkg::item_t it;
    it = random_fields(sdsf_pkg::CMD_START);
    it.command_byte = cmd_byte;
    it.argument     = arg;
    return it;
  endfunction

  function automatic sdsf_pkg::item_t rx_item(input logic [7:0] rx);
    sdsf_pkg::item_t it;
    it = random_fields(sdsf_pkg::CMD_RX);
    it.rx_byte = rx;
    return it;
  endfunction

  // Offers one item, waits for its transfer and records what it should cause.
  task automatic send_item(input sdsf_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= it;
    @(posedge clk);
    while (cmd_stall) begin
      @(posedge clk);
    end
    predict_framer(it);
  endtask

  // Waits until every predicted result has been seen and the framer has settled.
  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (spi_out_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Ends any open reply wait, then writes the poll limit while the framer is idle.
  task automatic set_poll_limit(input logic [7:0] value);
    if (card_waiting) begin
      send_item(rx_item(8'h00));
    end
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write    <= 1'b0;
    poll_limit_m  = value;
  endtask

  // Frames at the field extremes, known CRCs, and the ignored items.
  task automatic test_directed_frames();
    send_item(start_item(7'h40, 32'h0000_0000));
    send_item(rx_item(sdsf_pkg::IDLE_BYTE));
    send_item(rx_item(8'h01));
    send_item(rx_item(8'h00));
    send_item(rx_item(sdsf_pkg::IDLE_BYTE));
    send_item(start_item(7'h48, 32'h0000_01AA));
    send_item(start_item(7'h7F, 32'hFFFF_FFFF));
    send_item(rx_item(8'hFE));
    send_item(start_item(7'h7F, 32'hFFFF_FFFF));
    send_item(rx_item(8'h00));
    send_item(start_item(7'h00, 32'h8000_0001));
    send_item(rx_item(8'h80));
    wait_idle();
  endtask

  // Poll limits of zero, a few, one and the maximum, run out and answered.
  task automatic test_poll_limits();
    set_poll_limit(8'd0);
    send_item(start_item(7'h51, 32'h1234_5678));
    send_item(rx_item(sdsf_pkg::IDLE_BYTE));
    set_poll_limit(8'd3);
    send_item(start_item(7'h77, 32'hA5A5_5A5A));
    repeat (4) send_item(rx_item(sdsf_pkg::IDLE_BYTE));
    set_poll_limit(8'd255);
    send_item(start_item(7'h41, 32'h0000_0000));
    repeat (256) send_item(rx_item(sdsf_pkg::IDLE_BYTE));
    set_poll_limit(8'd1);
    send_item(start_item(7'h4D, 32'hDEAD_BEEF));
    send_item(rx_item(sdsf_pkg::IDLE_BYTE));
    send_item(rx_item(8'h7F));
    wait_idle();
  endtask

  // A long receiver hold-off while the sender keeps offering whole exchanges.
  task automatic test_backpressure();
    set_poll_limit(8'd2);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests <= hold_requests + 1;
    for (int f = 0; f < 4; f++) begin
      send_item(random_fields(sdsf_pkg::CMD_START));
      send_item(rx_item(sdsf_pkg::IDLE_BYTE));
      send_item(rx_item(8'h05));
    end
    wait_idle();
  endtask

  // Mostly well-formed exchanges with random content, plus some noise.
  task automatic run_random_phase(input int idle_pct, input int stall_v,
                                  input logic [7:0] limit, input int count);
    int    goal;
    int    pick;
    sdsf_pkg::item_t it;
    set_poll_limit(limit);
    send_idle_pct = idle_pct;
    stall_pct     = stall_v;
    goal = answered_items + count;
    while (answered_items < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        it = random_fields(1'($urandom_range(1)));
      end else if (!card_waiting) begin
        it = random_fields(sdsf_pkg::CMD_START);
      end else if (pick < 70 || (polls_left_m == 8'h00 && pick < 85)) begin
        it = rx_item(sdsf_pkg::IDLE_BYTE);
      end else begin
        it = rx_item(8'($urandom_range(254)));
      end
      send_item(it);
    end
    wait_idle();
  endtask

  task automatic test_random_traffic();
    run_random_phase(0, 0, 8'd0, PHASE_ITEMS);
    run_random_phase(66, 0, 8'($urandom_range(8, 1)), PHASE_ITEMS);
    run_random_phase(0, 66, 8'd255, PHASE_ITEMS);
    run_random_phase(22, 22, 8'($urandom_range(255)), PHASE_ITEMS);
  endtask

  // Receiver stall: random by percentage, or held for a long stretch on request.
  always @(posedge clk) begin
    if (rst) begin
      res_stall   <= 1'b0;
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      res_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Each result transfer is compared with the oldest prediction.
  always @(posedge clk) begin : check_results
    sdsf_pkg::result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (spi_out_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, res);
        fail_count++;
      end else begin
        want = spi_out_q.pop_front();
        report_field("tx_valid", 8'(want.tx_valid), 8'(res.tx_valid));
        report_field("tx_out", want.tx_out, res.tx_out);
        report_field("reply_valid", 8'(want.reply_valid), 8'(res.reply_valid));
        report_field("reply_byte", want.reply_byte, res.reply_byte);
        report_field("timed_out", 8'(want.timed_out), 8'(res.timed_out));
        report_field("last", 8'(want.last), 8'(res.last));
      end
    end
  end

  // Run limit.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** sd_spi_command_framer: FAILED **");
    $finish;
  end

  initial begin : main_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_poll_limits();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (fail_count == 0 && spi_out_q.size() == 0) begin
      $display("** sd_spi_command_framer: PASSED **");
    end else begin
      $display("** sd_spi_command_framer: FAILED **");
    end
    $finish;
  end

endmodule
